FILE: rtl/mbd_pkg.sv
package mbd_pkg;

   localparam int BUTTON_COUNT = 2;
   localparam int BUTTON_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam int TICKS_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // item kinds carried in tuser
   localparam logic [1:0] KIND_STEP  = 2'd0;
   localparam logic [1:0] KIND_EDGE  = 2'd1;
   localparam logic [1:0] KIND_TIMER = 2'd2;

   // register word indexes
   localparam logic [1:0] REG_POLL_MASK   = 2'd0;
   localparam logic [1:0] REG_ASYNC_MASK  = 2'd1;
   localparam logic [1:0] REG_DELAY_TICKS = 2'd2;

   // phase codes as reported on the result
   localparam logic [1:0] PHASE_CODE_IDLE       = 2'd0;
   localparam logic [1:0] PHASE_CODE_RECEIVED   = 2'd1;
   localparam logic [1:0] PHASE_CODE_WAITING    = 2'd2;
   localparam logic [1:0] PHASE_CODE_CONFIRMING = 2'd3;

   // per-button handler state
   typedef enum logic [3:0] {
      PH_IDLE       = 4'b0001,
      PH_RECEIVED   = 4'b0010,
      PH_WAITING    = 4'b0100,
      PH_CONFIRMING = 4'b1000
   } phase_type;

   // result word, stable_level in the lowest bit
   typedef struct packed {
      logic [1:0]         phase;
      logic [TICKS_W-1:0] timer_length;
      logic               start_timer;
      logic               status;
      logic               stable_level;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      code = PHASE_CODE_IDLE;
      case (ph)
         PH_IDLE:       code = PHASE_CODE_IDLE;
         PH_RECEIVED:   code = PHASE_CODE_RECEIVED;
         PH_WAITING:    code = PHASE_CODE_WAITING;
         PH_CONFIRMING: code = PHASE_CODE_CONFIRMING;
         default:       code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/multi_button_debounce_fsm.sv
// Debouncer for a small set of buttons, each with its own idle / received /
// waiting / confirming handler and a debounced level. One transaction on the
// req_ side names a button and carries a step with the sampled pin level, an
// edge event or a timer expiry (kind in req_tuser); each one yields exactly
// one rsp_ transaction with the button's new stable level, phase, the busy
// status for rejected edge events and, for async buttons, a timer request
// with the configured delay length. The handler update is a single short
// decode done as the transaction is taken, so one transaction is accepted
// every clock while the skid register is empty; its result is registered.
// A two-entry output buffer (result register plus skid register) takes one
// more result while rsp_tready is low; req_tready is low while the skid entry
// is full. Configuration (poll_mask, async_mask, delay_ticks at byte
// addresses 0, 4, 8) must be written only while no transaction is in flight.
module multi_button_debounce_fsm
   import mbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input transactions
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // button, level, zero fill
   input  logic [1:0]             req_tuser,   // kind
   // result transactions
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // stable_level, status, start_timer,
                                               // timer_length, phase, zero fill
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   // configuration registers
   logic [BUTTON_COUNT-1:0] poll_mask_ff;
   logic [BUTTON_COUNT-1:0] async_mask_ff;
   logic [TICKS_W-1:0]      delay_ticks_ff;

   // per-button state
   phase_type phase_ff [BUTTON_COUNT];
   logic      level_ff [BUTTON_COUNT];

   // output buffer
   rsp_type out_ff, skid_ff, out_in, skid_in;
   logic    out_valid_ff, skid_valid_ff, out_valid_in, skid_valid_in;

   // decode of the incoming transaction
   logic [BUTTON_W-1:0] btn;
   logic                smp;
   logic                req_fire;
   logic                csr_wr;
   phase_type           ph_cur, ph_new;
   logic                lvl_cur, lvl_new;
   rsp_type             res;

   assign btn      = req_tdata[BUTTON_W-1:0];
   assign smp      = req_tdata[BUTTON_W];
   assign req_fire = req_tvalid && req_tready;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // ---------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[3:2])
         REG_POLL_MASK:   csr_prdata = CSR_DATA_W'(poll_mask_ff);
         REG_ASYNC_MASK:  csr_prdata = CSR_DATA_W'(async_mask_ff);
         REG_DELAY_TICKS: csr_prdata = CSR_DATA_W'(delay_ticks_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_mask_ff   <= '1;
         async_mask_ff  <= '0;
         delay_ticks_ff <= TICKS_W'(20);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_POLL_MASK:   poll_mask_ff   <= csr_pwdata[BUTTON_COUNT-1:0];
            REG_ASYNC_MASK:  async_mask_ff  <= csr_pwdata[BUTTON_COUNT-1:0];
            REG_DELAY_TICKS: delay_ticks_ff <= csr_pwdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // handler update for the addressed button
   // ---------------------------------------------------------------
   always_comb begin
      ph_cur           = phase_ff[btn];
      lvl_cur          = level_ff[btn];
      ph_new           = ph_cur;
      lvl_new          = lvl_cur;
      res.status       = 1'b0;
      res.start_timer  = 1'b0;
      res.timer_length = '0;
      case (req_tuser)
         KIND_STEP: begin
            case (ph_cur)
               PH_IDLE: begin
                  // polled buttons start a debounce on a level change
                  if (poll_mask_ff[btn] && (smp != lvl_cur)) ph_new = PH_RECEIVED;
               end
               PH_RECEIVED: begin
                  if (async_mask_ff[btn]) begin
                     res.start_timer  = 1'b1;
                     res.timer_length = delay_ticks_ff;
                     ph_new           = PH_WAITING;
                  end else begin
                     ph_new = PH_CONFIRMING;
                  end
               end
               PH_CONFIRMING: begin
                  // adopt a differing sample, else settle back to idle
                  if (smp != lvl_cur) lvl_new = smp;
                  else                ph_new  = PH_IDLE;
               end
               default: ;
            endcase
         end
         KIND_EDGE: begin
            // busy buttons reject edge events
            if (ph_cur != PH_IDLE) res.status = 1'b1;
            else                   ph_new     = PH_RECEIVED;
         end
         KIND_TIMER: ph_new = PH_CONFIRMING;
         default: ;
      endcase
      res.stable_level = lvl_new;
      res.phase        = phase_code(ph_new);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            phase_ff[i] <= PH_IDLE;
            level_ff[i] <= 1'b0;
         end
      end else if (req_fire) begin
         phase_ff[btn] <= ph_new;
         level_ff[btn] <= lvl_new;
      end
   end

   // ---------------------------------------------------------------
   // output register with skid entry
   // ---------------------------------------------------------------
   assign req_tready = !skid_valid_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      if (skid_valid_ff) begin
         // no new transaction can arrive while the skid entry is full
         if (rsp_tready) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_tready) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_ff);

endmodule

FILE: rtl/mbd_checker.sv
module mbd_checker
   import mbd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rsp_type r;
   assign r = rsp_type'(rsp_tdata[RSP_W-1:0]);

   // nothing is shown the cycle after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a timer request always leaves the button waiting
   a_timer_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && r.start_timer) |-> (r.phase == PHASE_CODE_WAITING))
      else $error("timer request without waiting phase");

   // timer length only accompanies a request
   a_timer_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !r.start_timer) |-> (r.timer_length == '0))
      else $error("timer length without request");

   // a rejected edge event means the button was busy
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && r.status) |-> (r.phase != PHASE_CODE_IDLE && !r.start_timer))
      else $error("rejection reported for idle button");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind multi_button_debounce_fsm mbd_checker u_mbd_checker (.*);

FILE: tb/multi_button_debounce_fsm_tb.sv
module multi_button_debounce_fsm_tb;
   import mbd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // kind code that the block does not define, state must stay unchanged
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // longest run of cycles with no transaction on any port before giving up
   localparam int WATCHDOG_LIMIT = 3000;
   // receiver hold-off that backs the block up into its input
   localparam int LONG_HOLD_CYCLES = 60;
   // cycles the result path may still need after the last expected result
   localparam int SETTLE_CYCLES = 6;

   // predicted per-button debounce state and the results it implies
   class debounce_scoreboard;
      logic [1:0]               btn_phase [BUTTON_COUNT];
      logic                     btn_level [BUTTON_COUNT];
      logic [BUTTON_COUNT-1:0]  poll_bits;
      logic [BUTTON_COUNT-1:0]  async_bits;
      logic [TICKS_W-1:0]       delay_len;
      rsp_type                  pending_rsp [$];
      int                       mismatch_count;
      int                       unexpected_count;
      int                       checked_count;
      int                       timer_requests;

      function void power_on();
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            btn_phase[i] = PHASE_CODE_IDLE;
            btn_level[i] = 1'b0;
         end
         poll_bits  = 2'd3;
         async_bits = 2'd0;
         delay_len  = 16'd20;
         pending_rsp.delete();
      endfunction

      function void set_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_POLL_MASK:   poll_bits  = value[BUTTON_COUNT-1:0];
            REG_ASYNC_MASK:  async_bits = value[BUTTON_COUNT-1:0];
            REG_DELAY_TICKS: delay_len  = value[TICKS_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      // one accepted input transaction, one predicted result
      function void note_item(logic [1:0] kind, logic [BUTTON_W-1:0] btn, logic lvl);
         rsp_type    r;
         logic [1:0] ph;
         r  = '0;
         ph = btn_phase[btn];
         case (kind)
            KIND_STEP: begin
               case (ph)
                  PHASE_CODE_IDLE: begin
                     if (poll_bits[btn] && lvl != btn_level[btn])
                        ph = PHASE_CODE_RECEIVED;
                  end
                  PHASE_CODE_RECEIVED: begin
                     if (async_bits[btn]) begin
                        r.start_timer  = 1'b1;
                        r.timer_length = delay_len;
                        ph = PHASE_CODE_WAITING;
                     end else begin
                        ph = PHASE_CODE_CONFIRMING;
                     end
                  end
                  PHASE_CODE_CONFIRMING: begin
                     if (lvl != btn_level[btn])
                        btn_level[btn] = lvl;
                     else
                        ph = PHASE_CODE_IDLE;
                  end
                  default: ;
               endcase
            end
            KIND_EDGE: begin
               if (ph != PHASE_CODE_IDLE)
                  r.status = 1'b1;
               else
                  ph = PHASE_CODE_RECEIVED;
            end
            KIND_TIMER: ph = PHASE_CODE_CONFIRMING;
            default: ;
         endcase
         btn_phase[btn] = ph;
         r.stable_level = btn_level[btn];
         r.phase        = ph;
         pending_rsp.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= 10)
               $display("unexpected result transaction: %h", got);
            return;
         end
         want = pending_rsp.pop_front();
         checked_count++;
         if (got.start_timer)
            timer_requests++;
         if (got.stable_level !== want.stable_level || got.status !== want.status ||
             got.start_timer !== want.start_timer ||
             got.timer_length !== want.timer_length || got.phase !== want.phase) begin
            mismatch_count++;
            if (mismatch_count + unexpected_count <= 10) begin
               $display("result %0d differs: expected level %0d status %0d start %0d",
                        checked_count, want.stable_level, want.status, want.start_timer,
                        " len %0d phase %0d", want.timer_length, want.phase);
               $display("   got level %0d status %0d start %0d len %0d phase %0d",
                        got.stable_level, got.status, got.start_timer,
                        got.timer_length, got.phase);
            end
         end
      endfunction

      function logic level_of(logic [BUTTON_W-1:0] btn);
         return btn_level[btn];
      endfunction

      function logic [1:0] phase_of(logic [BUTTON_W-1:0] btn);
         return btn_phase[btn];
      endfunction

      function logic is_polled(logic [BUTTON_W-1:0] btn);
         return poll_bits[btn];
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;    // button, level, zero fill
   logic [1:0]             req_tuser;    // kind
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;    // stable_level, status, start_timer,
                                         // timer_length, phase, zero fill
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   debounce_scoreboard sb;

   // idling controls, switched per phase of the run
   bit req_gaps_on;
   bit rsp_stalls_on;
   bit rsp_hold_request;

   int items_sent;
   int idle_cycles = 0;
   int input_stall_cycles = 0;
   int long_holds_done;

   multi_button_debounce_fsm i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: any transaction on any port restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      // back-pressure seen on the input side
      if (!reset && req_tvalid && !req_tready)
         input_stall_cycles <= input_stall_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // offer one input transaction, optionally after a gap, and note it once taken
   task automatic send_item(input logic [1:0] kind, input logic [BUTTON_W-1:0] btn,
                            input logic lvl);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, lvl, btn};
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, btn, lvl);
      items_sent++;
   endtask

   // any kind including the unused code, any button, any level
   task automatic send_noise();
      logic [1:0] kind;
      case ($urandom_range(0, 15))
         0:       kind = KIND_UNUSED;
         1, 2, 3: kind = KIND_TIMER;
         4, 5, 6: kind = KIND_EDGE;
         default: kind = KIND_STEP;
      endcase
      send_item(kind, BUTTON_W'($urandom_range(0, BUTTON_COUNT - 1)),
                1'($urandom_range(0, 1)));
   endtask

   // a full debounce on one button: start, delay, confirm, settle back to idle
   task automatic run_debounce(input logic [BUTTON_W-1:0] btn);
      int n;
      // start by a level change on a polled button or by an edge event
      if (sb.is_polled(btn) && $urandom_range(0, 1))
         send_item(KIND_STEP, btn, !sb.level_of(btn));
      else
         send_item(KIND_EDGE, btn, 1'($urandom_range(0, 1)));
      // received: timer request for async buttons, else straight to confirming
      send_item(KIND_STEP, btn, 1'($urandom_range(0, 1)));
      if (sb.phase_of(btn) == PHASE_CODE_WAITING) begin
         n = $urandom_range(0, 2);
         repeat (n) send_item(KIND_STEP, btn, 1'($urandom_range(0, 1)));
         // edge while busy gets rejected
         if ($urandom_range(0, 3) == 0)
            send_item(KIND_EDGE, btn, 1'($urandom_range(0, 1)));
         send_item(KIND_TIMER, btn, 1'($urandom_range(0, 1)));
      end
      // confirming: random samples, each differing one is adopted
      n = $urandom_range(0, 3);
      repeat (n) send_item(KIND_STEP, btn, 1'($urandom_range(0, 1)));
      send_item(KIND_STEP, btn, sb.level_of(btn));
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic configure(input logic [1:0] poll, input logic [1:0] async_bits,
                            input logic [TICKS_W-1:0] ticks);
      csr_write(REG_POLL_MASK, CSR_DATA_W'(poll));
      csr_write(REG_ASYNC_MASK, CSR_DATA_W'(async_bits));
      csr_write(REG_DELAY_TICKS, CSR_DATA_W'(ticks));
   endtask

   // park the input side until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input int count, input bit pause_midway);
      int start;
      bit paused;
      start  = items_sent;
      paused = 1'b0;
      while (items_sent - start < count) begin
         if ($urandom_range(0, 9) < 7)
            run_debounce(BUTTON_W'($urandom_range(0, BUTTON_COUNT - 1)));
         else
            send_noise();
         // sender pause until the result side has fully caught up
         if (pause_midway && !paused && items_sent - start >= count / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   // result side: random stalls, one long hold-off on request
   task automatic collect_results();
      int stall;
      forever begin
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
            long_holds_done++;
         end else begin
            stall = rsp_stalls_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_type'(rsp_tdata[RSP_W-1:0]));
      end
   endtask

   initial begin
      // every input known from time zero
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= KIND_STEP;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      items_sent         = 0;
      long_holds_done    = 0;
      rsp_hold_request   = 1'b0;
      req_gaps_on        = 1'b1;
      rsp_stalls_on      = 1'b1;
      sb = new();
      sb.power_on();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_results();
      join_none

      // directed, reset configuration: polled, immediate delay
      send_item(KIND_STEP, 1'b0, 1'b1);     // idle, level change starts debounce
      send_item(KIND_STEP, 1'b0, 1'b1);     // received goes straight to confirming
      send_item(KIND_STEP, 1'b0, 1'b1);     // confirming adopts pressed
      send_item(KIND_STEP, 1'b0, 1'b1);     // same level, back to idle
      send_item(KIND_EDGE, 1'b1, 1'b0);     // edge on idle button
      send_item(KIND_EDGE, 1'b1, 1'b1);     // edge on busy button is rejected
      send_item(KIND_TIMER, 1'b1, 1'b1);    // expiry forces confirming
      send_item(KIND_STEP, 1'b1, 1'b0);     // equal to stable level, idle again
      send_item(KIND_UNUSED, 1'b0, 1'b1);   // unused kind only reports state
      send_item(KIND_UNUSED, 1'b1, 1'b0);
      drain_results();

      // directed, edge-driven buttons with external timer and longest delay
      configure(2'd0, 2'd3, 16'hFFFF);
      send_item(KIND_STEP, 1'b0, 1'b0);     // not polled, no start from a step
      send_item(KIND_STEP, 1'b1, 1'b1);
      send_item(KIND_EDGE, 1'b0, 1'b1);     // edge starts debounce on unpolled button
      send_item(KIND_STEP, 1'b0, 1'b1);     // timer request with delay length
      send_item(KIND_STEP, 1'b0, 1'b0);     // waiting ignores steps
      send_item(KIND_EDGE, 1'b0, 1'b0);     // rejected while waiting
      send_item(KIND_TIMER, 1'b0, 1'b0);
      send_item(KIND_STEP, 1'b0, 1'b0);     // differs from pressed, adopt released
      send_item(KIND_STEP, 1'b0, 1'b1);     // adopt pressed
      send_item(KIND_STEP, 1'b0, 1'b1);     // settle to idle
      send_item(KIND_TIMER, 1'b1, 1'b0);    // expiry on an idle button
      drain_results();

      // random phases, each with its own register setting and idling mix
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(2'd3, 2'd3, 16'd0);
            1: configure(2'd0, 2'd0, 16'hFFFF);
            2: configure(2'd1, 2'd2, TICKS_W'($urandom_range(0, 65535)));
            3: configure(2'd2, 2'd1, TICKS_W'($urandom_range(0, 65535)));
            default: configure(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               TICKS_W'($urandom_range(0, 65535)));
         endcase
         // phase 0 runs with no idling at all, phase 4 backs up the block
         req_gaps_on   = (ph != 0) && (ph != 4) && ($urandom_range(0, 3) != 0);
         rsp_stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         if (ph == 4)
            rsp_hold_request = 1'b1;
         random_phase(72, ph == 3);
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d input transactions and %0d checked results, %0d timer requests",
               items_sent, sb.checked_count, sb.timer_requests);
      $display("back-pressure: %0d input stall cycles, %0d long result hold-offs",
               input_stall_cycles, long_holds_done);
      if (sb.mismatch_count == 0 && sb.unexpected_count == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing results",
                  sb.mismatch_count, sb.unexpected_count, sb.pending());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
